// File: rtl/stateful_flow_firewall_unit_assert.svh
// Assertion macros for the stateful flow firewall unit.
`ifndef STATEFUL_FLOW_FIREWALL_UNIT_ASSERT_SVH
`define STATEFUL_FLOW_FIREWALL_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SFF_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("implication check failed");
`define SFF_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define SFF_ASSERT_IMP(label, clk, rst, a, c)
`define SFF_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// File: rtl/sff_pkg.sv
// Package: constants and types of the stateful flow firewall unit.
package sff_pkg;
  localparam int FlowEntries = 256;
  localparam int IdxW = $clog2(FlowEntries);
  localparam int CntW = IdxW + 1;
  localparam int KeyW = 96;
  localparam int StampW = 64;
  localparam logic [31:0] ExpiryReset = 32'd1000000000;
  localparam logic [15:0] EtypeIpv4 = 16'h0800;
  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;
  localparam logic [1:0] VerdictDrop = 2'd0;
  localparam logic [1:0] VerdictWan = 2'd1;
  localparam logic [1:0] VerdictLan = 2'd2;
  localparam logic [0:0] AddrExpiry = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_WRITE,
    ST_DONE
  } state_t;
endpackage

// File: rtl/sff_ram.sv
// Generic single-port RAM with registered read.
module sff_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: rtl/stateful_flow_firewall_unit.sv
// Top level: stateful flow firewall with a sequentially scanned flow table.
// channel | valid    | stall     | payload
// in      | in_valid | in_stall  | from_wan .. now_ns
// out     | out_valid| out_stall | verdict, table_full
// cfg     | psel/penable/pwrite  | paddr, pwdata
// After reset a clearing pass zeroes the valid table.
// Each item scans every entry through one RAM port.
// Expiry, match and first free slot are found in one pass over the table.
// A result waits in an output register; the next item is taken once it is gone.
`include "stateful_flow_firewall_unit_assert.svh"
module stateful_flow_firewall_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        from_wan,
  input  logic [15:0] eth_type,
  input  logic [7:0]  ip_proto,
  input  logic [31:0] ip_src,
  input  logic [31:0] ip_dst,
  input  logic [15:0] src_l4_port,
  input  logic [15:0] dst_l4_port,
  input  logic [63:0] now_ns,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  verdict,
  output logic        table_full,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int RamW = sff_pkg::KeyW + sff_pkg::StampW;

  sff_pkg::state_t state, state_next;
  logic [31:0] expiry_ns;
  logic [sff_pkg::FlowEntries-1:0] valid_bits;
  logic [sff_pkg::CntW-1:0] cnt;
  logic [sff_pkg::IdxW-1:0] rd_idx;
  logic wan, good, hit, free_seen;
  logic [sff_pkg::IdxW-1:0] hit_idx, free_idx;
  logic [sff_pkg::KeyW-1:0] key;
  logic [63:0] now, cutoff;
  logic ram_we;
  logic [sff_pkg::IdxW-1:0] ram_addr;
  logic [RamW-1:0] ram_wdata, ram_rdata;
  logic rd_live, expired, match;

  assign pready = 1'b1;
  assign prdata = (paddr == sff_pkg::AddrExpiry) ? expiry_ns : 32'd0;
  assign in_stall = (state != sff_pkg::ST_IDLE) || out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      expiry_ns <= sff_pkg::ExpiryReset;
    end else if (psel && penable && pwrite && paddr == sff_pkg::AddrExpiry) begin
      expiry_ns <= pwdata;
    end
  end

  assign rd_live = valid_bits[rd_idx];
  assign expired = ram_rdata[sff_pkg::StampW-1:0] < cutoff;
  assign match = rd_live && !expired && ram_rdata[RamW-1:sff_pkg::StampW] == key;

  always_comb begin
    state_next = state;
    ram_we = 1'b0;
    ram_addr = cnt[sff_pkg::IdxW-1:0];
    ram_wdata = {key, now};
    case (state)
      sff_pkg::ST_CLEAR: begin
        if (cnt == sff_pkg::CntW'(sff_pkg::FlowEntries - 1)) state_next = sff_pkg::ST_IDLE;
      end
      sff_pkg::ST_IDLE: begin
        if (in_valid && !in_stall) state_next = sff_pkg::ST_SCAN;
      end
      sff_pkg::ST_SCAN: begin
        if (cnt == sff_pkg::CntW'(sff_pkg::FlowEntries - 1)) state_next = sff_pkg::ST_CHECK;
      end
      sff_pkg::ST_CHECK: begin
        state_next = sff_pkg::ST_WRITE;
      end
      sff_pkg::ST_WRITE: begin
        ram_addr = hit ? hit_idx : free_idx;
        ram_we = good && (hit || (!wan && free_seen));
        state_next = sff_pkg::ST_DONE;
      end
      sff_pkg::ST_DONE: begin
        state_next = sff_pkg::ST_IDLE;
      end
      default: state_next = sff_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sff_pkg::ST_CLEAR;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        sff_pkg::ST_CLEAR: begin
          valid_bits[cnt[sff_pkg::IdxW-1:0]] <= 1'b0;
          cnt <= (state_next == sff_pkg::ST_IDLE) ? '0 : cnt + 1'b1;
        end
        sff_pkg::ST_IDLE: begin
          cnt <= '0;
          hit <= 1'b0;
          free_seen <= 1'b0;
          wan <= from_wan;
          good <= eth_type == sff_pkg::EtypeIpv4 &&
                  (ip_proto == sff_pkg::ProtoTcp || ip_proto == sff_pkg::ProtoUdp);
          key <= from_wan ? {ip_dst, ip_src, dst_l4_port, src_l4_port}
                          : {ip_src, ip_dst, src_l4_port, dst_l4_port};
          now <= now_ns;
          cutoff <= (now_ns >= {32'd0, expiry_ns}) ? now_ns - {32'd0, expiry_ns} : 64'd0;
        end
        sff_pkg::ST_SCAN, sff_pkg::ST_CHECK: begin
          if (state == sff_pkg::ST_SCAN) cnt <= cnt + 1'b1;
          if (cnt != '0 || state == sff_pkg::ST_CHECK) begin
            if (rd_live && expired) valid_bits[rd_idx] <= 1'b0;
            if (match && !hit) begin
              hit <= 1'b1;
              hit_idx <= rd_idx;
            end
            if ((!rd_live || expired) && !free_seen) begin
              free_seen <= 1'b1;
              free_idx <= rd_idx;
            end
          end
        end
        sff_pkg::ST_WRITE: begin
          if (ram_we) valid_bits[ram_addr] <= 1'b1;
          out_valid <= 1'b1;
          table_full <= good && !wan && !hit && !free_seen;
          verdict <= !good ? sff_pkg::VerdictDrop :
                     !wan ? sff_pkg::VerdictWan :
                     hit ? sff_pkg::VerdictLan : sff_pkg::VerdictDrop;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= ram_addr;
  end

  sff_ram #(.Width(RamW), .Depth(sff_pkg::FlowEntries)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  `SFF_ASSERT_IMP(a_no_accept_busy, clk, rst, state != sff_pkg::ST_IDLE, in_stall)
  `SFF_ASSERT_NXT(a_write_gives_out, clk, rst, state == sff_pkg::ST_WRITE, out_valid)
  `SFF_ASSERT_IMP(a_full_only_lan, clk, rst, out_valid && table_full,
                  verdict == sff_pkg::VerdictWan)
endmodule

// File: dv/stateful_flow_firewall_unit_tb.sv
// Testbench: stateful flow firewall unit, scoreboard against a flow table predictor.
`timescale 1ns / 100ps
module stateful_flow_firewall_unit_tb;

  typedef struct {
    bit        from_wan;
    bit [15:0] etype;
    bit [7:0]  proto;
    bit [31:0] sip;
    bit [31:0] dip;
    bit [15:0] sport;
    bit [15:0] dport;
    bit [63:0] now;
  } pkt_t;

  typedef struct {
    bit [1:0] verdict;
    bit       full;
  } pkt_verdict_t;

  typedef struct {
    bit [31:0] a_ip;
    bit [31:0] b_ip;
    bit [15:0] a_port;
    bit [15:0] b_port;
  } tuple_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        from_wan = 1'b0;
  logic [15:0] eth_type = '0;
  logic [7:0]  ip_proto = '0;
  logic [31:0] ip_src = '0;
  logic [31:0] ip_dst = '0;
  logic [15:0] src_l4_port = '0;
  logic [15:0] dst_l4_port = '0;
  logic [63:0] now_ns = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  verdict;
  logic        table_full;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [0:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  stateful_flow_firewall_unit DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  bit [95:0]    flow_key_q [sff_pkg::FlowEntries];
  bit [63:0]    flow_stamp_q [sff_pkg::FlowEntries];
  bit           flow_live_q [sff_pkg::FlowEntries];
  bit [31:0]    expiry_cfg = sff_pkg::ExpiryReset;

  pkt_t         pending_pkts[$];
  pkt_verdict_t verdict_fifo[$];
  tuple_t       flow_pool[64];
  int           fail_cnt = 0;
  int           pkt_cnt = 0;
  int           drop_cnt = 0;
  int           lan_cnt = 0;
  int           full_cnt = 0;
  int           cfg_cnt = 0;
  bit [63:0]    t_now;

  task automatic firewall_predict(input pkt_t p);
    bit [63:0]    cutoff;
    bit [95:0]    key;
    int           hit;
    int           slot;
    pkt_verdict_t r;
    cutoff = (p.now >= {32'b0, expiry_cfg}) ? p.now - {32'b0, expiry_cfg} : 64'd0;
    for (int i = 0; i < sff_pkg::FlowEntries; i++)
      if (flow_live_q[i] && flow_stamp_q[i] < cutoff) flow_live_q[i] = 1'b0;
    r.verdict = sff_pkg::VerdictDrop;
    r.full = 1'b0;
    if (p.etype == sff_pkg::EtypeIpv4 &&
        (p.proto == sff_pkg::ProtoTcp || p.proto == sff_pkg::ProtoUdp)) begin
      key = p.from_wan ? {p.dip, p.sip, p.dport, p.sport} : {p.sip, p.dip, p.sport, p.dport};
      hit = -1;
      slot = -1;
      for (int i = 0; i < sff_pkg::FlowEntries; i++) begin
        if (flow_live_q[i] && flow_key_q[i] == key && hit < 0) hit = i;
        if (!flow_live_q[i] && slot < 0) slot = i;
      end
      if (hit >= 0) begin
        flow_stamp_q[hit] = p.now;
        r.verdict = p.from_wan ? sff_pkg::VerdictLan : sff_pkg::VerdictWan;
      end else if (!p.from_wan) begin
        r.verdict = sff_pkg::VerdictWan;
        if (slot >= 0) begin
          flow_key_q[slot] = key;
          flow_stamp_q[slot] = p.now;
          flow_live_q[slot] = 1'b1;
        end else begin
          r.full = 1'b1;
        end
      end
    end
    if (r.verdict == sff_pkg::VerdictDrop) drop_cnt++;
    if (r.verdict == sff_pkg::VerdictLan) lan_cnt++;
    if (r.full) full_cnt++;
    verdict_fifo.push_back(r);
  endtask

  // driver
  int   in_gap = 0;
  bit   in_idling = 1'b1;
  pkt_t cur_pkt;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        firewall_predict(cur_pkt);
        pkt_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_pkts.size() > 0) begin
          cur_pkt = pending_pkts.pop_front();
          from_wan <= cur_pkt.from_wan;
          eth_type <= cur_pkt.etype;
          ip_proto <= cur_pkt.proto;
          ip_src <= cur_pkt.sip;
          ip_dst <= cur_pkt.dip;
          src_l4_port <= cur_pkt.sport;
          dst_l4_port <= cur_pkt.dport;
          now_ns <= cur_pkt.now;
          in_valid <= 1'b1;
          if ($urandom_range(0, 39) == 0) in_idling = !in_idling;
          in_gap = in_idling ? $urandom_range(0, 17) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int  out_wait = 0;
  bit  out_idling = 1'b1;
  always @(posedge clk) begin
    pkt_verdict_t exp_r;
    int n;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (verdict_fifo.size() == 0) begin
          $error("result with no packet pending: verdict %0d table_full %0d",
                 verdict, table_full);
          fail_cnt++;
        end else begin
          exp_r = verdict_fifo.pop_front();
          if (verdict !== exp_r.verdict) begin
            $error("verdict: expected %0d, actual %0d", exp_r.verdict, verdict);
            fail_cnt++;
          end
          if (table_full !== exp_r.full) begin
            $error("table_full: expected %0d, actual %0d", exp_r.full, table_full);
            fail_cnt++;
          end
        end
        if ($urandom_range(0, 39) == 0) out_idling = !out_idling;
        n = out_idling ? $urandom_range(0, 17) : 0;
        out_wait <= n;
        out_stall <= (n != 0);
      end else if (out_valid && out_stall) begin
        out_wait <= out_wait - 1;
        out_stall <= (out_wait > 1);
      end
    end
  end

  // watchdog
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("watchdog: no progress for %0d cycles", quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_pkt(input bit wan, input bit [15:0] et, input bit [7:0] pr,
                          input tuple_t t, input bit [63:0] tm);
    pkt_t p;
    p.from_wan = wan;
    p.etype = et;
    p.proto = pr;
    p.sip = t.a_ip;
    p.dip = t.b_ip;
    p.sport = t.a_port;
    p.dport = t.b_port;
    p.now = tm;
    pending_pkts.push_back(p);
  endtask

  function automatic tuple_t flip(input tuple_t t);
    tuple_t f;
    f.a_ip = t.b_ip;
    f.b_ip = t.a_ip;
    f.a_port = t.b_port;
    f.b_port = t.a_port;
    return f;
  endfunction

  function automatic tuple_t rand_tuple();
    tuple_t t;
    t.a_ip = $urandom;
    t.b_ip = $urandom;
    t.a_port = 16'($urandom);
    t.b_port = 16'($urandom);
    return t;
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_pkts.size() > 0 || in_valid || verdict_fifo.size() > 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_expiry(input bit [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= sff_pkg::AddrExpiry;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    expiry_cfg = v;
    cfg_cnt++;
  endtask

  task automatic run_phase(input int n, input int fill, input int step_max);
    tuple_t    t;
    bit        wan;
    bit [7:0]  pr;
    int        slot;
    for (int k = 0; k < n; k++) begin
      t_now += 64'($urandom_range(0, step_max));
      if ($urandom_range(0, 49) == 0) t_now -= 64'($urandom_range(0, step_max));
      pr = $urandom_range(0, 1) ? sff_pkg::ProtoTcp : sff_pkg::ProtoUdp;
      if ($urandom_range(0, 99) < 10) begin
        push_pkt(1'($urandom_range(0, 1)),
                 $urandom_range(0, 1) ? sff_pkg::EtypeIpv4 : 16'($urandom),
                 8'($urandom), rand_tuple(), t_now);
      end else if (k < fill) begin
        t = rand_tuple();
        push_pkt(1'b0, sff_pkg::EtypeIpv4, pr, t, t_now);
        flow_pool[k % 64] = t;
      end else begin
        wan = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 70) begin
          t = flow_pool[$urandom_range(0, 63)];
          if (wan && $urandom_range(0, 9) < 8) t = flip(t);
        end else begin
          t = rand_tuple();
          slot = $urandom_range(0, 63);
          if (!wan) flow_pool[slot] = t;
        end
        push_pkt(wan, sff_pkg::EtypeIpv4, pr, t, t_now);
      end
    end
  endtask

  initial begin
    tuple_t ta, tb, tc;
    for (int i = 0; i < 64; i++) flow_pool[i] = rand_tuple();
    ta = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF};
    tb = '{32'h0, 32'h0, 16'h0, 16'h0};
    tc = '{32'h0A00_0001, 32'hC0A8_0101, 16'd1234, 16'd80};
    // directed: drops, insert/reply, early time, expiry, time going back, max time
    push_pkt(1'b0, 16'hFFFF, sff_pkg::ProtoTcp, ta, 64'd0);
    push_pkt(1'b0, sff_pkg::EtypeIpv4, 8'hFF, ta, 64'd0);
    push_pkt(1'b1, sff_pkg::EtypeIpv4, 8'h00, tb, 64'd0);
    push_pkt(1'b1, 16'h0000, sff_pkg::ProtoUdp, ta, 64'd0);
    push_pkt(1'b0, sff_pkg::EtypeIpv4, sff_pkg::ProtoTcp, ta, 64'd0);
    push_pkt(1'b1, sff_pkg::EtypeIpv4, sff_pkg::ProtoTcp, flip(ta), 64'd10);
    push_pkt(1'b1, sff_pkg::EtypeIpv4, sff_pkg::ProtoUdp, tc, 64'd20);
    push_pkt(1'b0, sff_pkg::EtypeIpv4, sff_pkg::ProtoUdp, tb, 64'd30);
    push_pkt(1'b1, sff_pkg::EtypeIpv4, sff_pkg::ProtoUdp, flip(tb), 64'd40);
    push_pkt(1'b0, sff_pkg::EtypeIpv4, sff_pkg::ProtoTcp, ta, 64'd999_999_999);
    push_pkt(1'b1, sff_pkg::EtypeIpv4, sff_pkg::ProtoTcp, flip(tb), 64'd1_500_000_000);
    push_pkt(1'b1, sff_pkg::EtypeIpv4, sff_pkg::ProtoTcp, flip(ta), 64'd1_999_999_999);
    push_pkt(1'b1, sff_pkg::EtypeIpv4, sff_pkg::ProtoTcp, flip(ta), 64'd2_000_000_000);
    push_pkt(1'b0, sff_pkg::EtypeIpv4, sff_pkg::ProtoTcp, tc, 64'd3_000_000_000);
    push_pkt(1'b1, sff_pkg::EtypeIpv4, sff_pkg::ProtoTcp, flip(tc), 64'd500_000_000);
    push_pkt(1'b0, 16'h0806, sff_pkg::ProtoTcp, tc, 64'd3_900_000_000);
    push_pkt(1'b1, sff_pkg::EtypeIpv4, sff_pkg::ProtoTcp, flip(tc), 64'hFFFF_FFFF_FFFF_FFFF);
    push_pkt(1'b0, 16'hF7FF, 8'hF9, ta, 64'hFFFF_FFFF_FFFF_FFFF);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait_idle();
    t_now = 64'd0;

    write_expiry(32'hFFFF_FFFF);
    run_phase(340, 270, 3);
    wait_idle();
    // zero timeout before the low end, flushes the full table
    write_expiry(32'd0);
    t_now += 64'd10;
    run_phase(150, 0, 1);
    wait_idle();
    write_expiry(32'd1);
    run_phase(300, 0, 2);
    wait_idle();
    write_expiry($urandom_range(50, 400));
    run_phase(350, 0, 100);
    wait_idle();
    write_expiry(sff_pkg::ExpiryReset);
    run_phase(200, 0, 300_000_000);
    wait_idle();
    repeat (300) @(posedge clk);
    if (verdict_fifo.size() > 0) begin
      $error("%0d results never arrived", verdict_fifo.size());
      fail_cnt++;
    end
    $display("%0d packets: %0d dropped, %0d replies to LAN, %0d table-full flags",
             pkt_cnt, drop_cnt, lan_cnt, full_cnt);
    $display("%0d timeout settings applied, mismatches: %0d", cfg_cnt, fail_cnt);
    if (fail_cnt == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

// File: sim.f
+incdir+rtl
rtl/sff_pkg.sv
rtl/sff_ram.sv
rtl/stateful_flow_firewall_unit.sv
dv/stateful_flow_firewall_unit_tb.sv
